// ===== rtl/core/sarc_pkg.sv =====
// package for the serial actuator relay controller
// holds payload structs, reply and status codes, command characters and defaults
// no dependencies
package sarc_pkg;

    localparam int LINE_BUFFER_DEPTH_DEF = 16;
    localparam logic [7:0] ACTIVE_TICKS_RESET = 8'd30;

    // register map
    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_ACTIVE_TICKS = 1'b0;

    // command field
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // replies
    localparam logic [1:0] REPLY_NONE   = 2'd0;
    localparam logic [1:0] REPLY_ACK    = 2'd1;
    localparam logic [1:0] REPLY_NAK    = 2'd2;
    localparam logic [1:0] REPLY_STATUS = 2'd3;

    // cover states
    localparam logic [1:0] ST_STOPPED = 2'd0;
    localparam logic [1:0] ST_OPEN    = 2'd1;
    localparam logic [1:0] ST_CLOSED  = 2'd2;

    // characters
    localparam logic [7:0] CH_CLOSE  = 8'h43;
    localparam logic [7:0] CH_OPEN   = 8'h4F;
    localparam logic [7:0] CH_STOP   = 8'h53;
    localparam logic [7:0] CH_STATUS = 8'h3F;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] reply;
        logic [2:0] status_code;
        logic       open_relay_out;
        logic       close_relay_out;
    } t_out_item;

endpackage

// ===== rtl/core/serial_actuator_relay_controller_top.sv =====
// top level of the serial actuator relay controller
// command line parser, tick driven relay sequencer and apb register port
// depends on sarc_pkg

// One item (a received byte or a tick) is taken per clock and produces
// exactly one result item. An item passes an input register, then the
// state update logic that writes the result register; the sustained rate
// is one item per cycle and only drops when the result register is held
// by a stalled consumer. Register active_ticks (byte address 0) sets how
// many ticks a relay stays on after an open or close starts; 0 leaves it
// on until the cover is stopped. A stop, open or close request takes
// effect on the following ticks: a moving or driven cover is first stopped,
// then driven toward the requested state on a later tick.
module serial_actuator_relay_controller_top #(
    parameter int LINE_BUFFER_DEPTH = sarc_pkg::LINE_BUFFER_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item input
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  sarc_pkg::t_in_item              i_in_item,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output sarc_pkg::t_out_item             o_out_item,
    // apb register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sarc_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import sarc_pkg::*;

    localparam int LEN_W = $clog2(LINE_BUFFER_DEPTH + 1);

    // registers
    logic [7:0]       r_active_ticks;
    logic             r_in_valid;
    t_in_item         r_in_item;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic [LEN_W-1:0] r_line_length;
    logic [7:0]       r_first_char;
    logic [1:0]       r_wanted_state;
    logic [1:0]       r_present_state;
    logic [7:0]       r_drive_ticks_left;
    logic             r_open_relay_on;
    logic             r_close_relay_on;

    // next values
    logic [LEN_W-1:0] n_line_length;
    logic [7:0]       n_first_char;
    logic [1:0]       n_wanted_state;
    logic [1:0]       n_present_state;
    logic [7:0]       n_drive_ticks_left;
    logic             n_open_relay_on;
    logic             n_close_relay_on;
    logic [1:0]       n_reply;
    logic [2:0]       n_status;

    logic advance;
    logic cfg_write;
    logic is_term;

    // apb
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[PADDR_W-1] == REG_ACTIVE_TICKS) ? {24'd0, r_active_ticks} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_ticks <= ACTIVE_TICKS_RESET;
        end else if (cfg_write && paddr[PADDR_W-1] == REG_ACTIVE_TICKS) begin
            r_active_ticks <= pwdata[7:0];
        end
    end

    // handshake: input register feeds result register
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign is_term = (r_in_item.rx_byte == CH_CR) || (r_in_item.rx_byte == CH_LF);

    always_comb begin
        n_line_length      = r_line_length;
        n_first_char       = r_first_char;
        n_wanted_state     = r_wanted_state;
        n_present_state    = r_present_state;
        n_drive_ticks_left = r_drive_ticks_left;
        n_open_relay_on    = r_open_relay_on;
        n_close_relay_on   = r_close_relay_on;
        n_reply            = REPLY_NONE;

        if (r_in_item.command == CMD_TICK) begin
            if (r_drive_ticks_left != 8'd0) begin
                n_drive_ticks_left = r_drive_ticks_left - 8'd1;
                if (r_drive_ticks_left == 8'd1) begin
                    n_open_relay_on  = 1'b0;
                    n_close_relay_on = 1'b0;
                end
            end
            if (r_wanted_state != r_present_state) begin
                if (r_present_state != ST_STOPPED) begin
                    n_open_relay_on    = 1'b0;
                    n_close_relay_on   = 1'b0;
                    n_present_state    = ST_STOPPED;
                    n_drive_ticks_left = 8'd0;
                end else if (r_wanted_state == ST_OPEN) begin
                    n_open_relay_on    = 1'b1;
                    n_present_state    = ST_OPEN;
                    n_drive_ticks_left = r_active_ticks;
                end else if (r_wanted_state == ST_CLOSED) begin
                    n_close_relay_on   = 1'b1;
                    n_present_state    = ST_CLOSED;
                    n_drive_ticks_left = r_active_ticks;
                end
            end
        end else if (r_line_length != '0 && is_term) begin
            n_reply       = REPLY_NAK;
            n_line_length = '0;
            if (r_line_length == LEN_W'(1)) begin
                unique case (r_first_char)
                    CH_STATUS: n_reply = REPLY_STATUS;
                    CH_CLOSE: begin
                        n_wanted_state = ST_CLOSED;
                        n_reply        = REPLY_ACK;
                    end
                    CH_OPEN: begin
                        n_wanted_state = ST_OPEN;
                        n_reply        = REPLY_ACK;
                    end
                    CH_STOP: begin
                        n_wanted_state = ST_STOPPED;
                        n_reply        = REPLY_ACK;
                    end
                    default: n_reply = REPLY_NAK;
                endcase
            end
        end else begin
            // a terminator on an empty line is kept like any byte
            if (r_line_length == '0) begin
                n_first_char = r_in_item.rx_byte;
            end
            if (r_line_length < LEN_W'(LINE_BUFFER_DEPTH)) begin
                n_line_length = r_line_length + LEN_W'(1);
            end
        end

        // a running move counter reports opening or closing
        n_status = {1'b0, n_present_state} + ((n_drive_ticks_left != 8'd0) ? 3'd2 : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_line_length      <= '0;
            r_wanted_state     <= ST_STOPPED;
            r_present_state    <= ST_STOPPED;
            r_drive_ticks_left <= 8'd0;
            r_open_relay_on    <= 1'b0;
            r_close_relay_on   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_line_length      <= n_line_length;
                r_wanted_state     <= n_wanted_state;
                r_present_state    <= n_present_state;
                r_drive_ticks_left <= n_drive_ticks_left;
                r_open_relay_on    <= n_open_relay_on;
                r_close_relay_on   <= n_close_relay_on;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_first_char               <= n_first_char;
            r_out_item.reply           <= n_reply;
            r_out_item.status_code     <= n_status;
            r_out_item.open_relay_out  <= n_open_relay_on;
            r_out_item.close_relay_out <= n_close_relay_on;
        end
    end

endmodule

// ===== sim/testbench.sv =====
// testbench for serial_actuator_relay_controller_top: directed table, then random command lines
// and tick runs, untyped results checked against a cycle-free model of the line parser and relays
// typed table rows are checked as given; depends on sarc_pkg and the rtl top level
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sarc_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 40;

    // status values reported in status_code
    localparam logic [2:0] STAT_STOPPED = 3'd0;
    localparam logic [2:0] STAT_OPEN    = 3'd1;
    localparam logic [2:0] STAT_CLOSED  = 3'd2;
    localparam logic [2:0] STAT_OPENING = 3'd3;
    localparam logic [2:0] STAT_CLOSING = 3'd4;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_in_item in_item = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out_item o_out_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    serial_actuator_relay_controller_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // model of the controller
    logic [7:0] cfg_active_ticks;
    logic [4:0] ln_len;
    logic [7:0] first_ch;
    logic [1:0] want_st;
    logic [1:0] cur_st;
    logic [7:0] ticks_left;
    logic       open_on;
    logic       close_on;

    t_out_item relay_results_due[$];
    int n_err = 0;
    int cycle_cnt = 0;
    int items_sent = 0;
    bit hold_request = 1'b0;

    function automatic t_out_item out_of(logic [1:0] r, logic [2:0] s, logic o, logic c);
        t_out_item v;
        v.reply = r;
        v.status_code = s;
        v.open_relay_out = o;
        v.close_relay_out = c;
        return v;
    endfunction

    function automatic t_in_item mk_byte(logic [7:0] b);
        t_in_item v;
        v.command = CMD_BYTE;
        v.rx_byte = b;
        return v;
    endfunction

    function automatic t_in_item mk_tick(logic [7:0] junk);
        t_in_item v;
        v.command = CMD_TICK;
        v.rx_byte = junk;
        return v;
    endfunction

    function automatic void model_reset();
        cfg_active_ticks = ACTIVE_TICKS_RESET;
        ln_len = '0;
        first_ch = '0;
        want_st = ST_STOPPED;
        cur_st = ST_STOPPED;
        ticks_left = '0;
        open_on = 1'b0;
        close_on = 1'b0;
    endfunction

    function automatic t_out_item predict_relay_item(t_in_item it);
        logic [1:0] r;
        logic [2:0] s;
        r = REPLY_NONE;
        if (it.command == CMD_TICK) begin
            if (ticks_left != 0) begin
                ticks_left = ticks_left - 8'd1;
                if (ticks_left == 0) begin
                    open_on = 1'b0;
                    close_on = 1'b0;
                end
            end
            if (want_st != cur_st) begin
                if (cur_st != ST_STOPPED) begin
                    open_on = 1'b0;
                    close_on = 1'b0;
                    cur_st = ST_STOPPED;
                    ticks_left = '0;
                end else if (want_st == ST_OPEN) begin
                    open_on = 1'b1;
                    cur_st = ST_OPEN;
                    ticks_left = cfg_active_ticks;
                end else if (want_st == ST_CLOSED) begin
                    close_on = 1'b1;
                    cur_st = ST_CLOSED;
                    ticks_left = cfg_active_ticks;
                end
            end
        end else if (ln_len != 0 && (it.rx_byte == CH_CR || it.rx_byte == CH_LF)) begin
            r = REPLY_NAK;
            if (ln_len == 5'd1) begin
                if (first_ch == CH_STATUS) begin
                    r = REPLY_STATUS;
                end else if (first_ch == CH_CLOSE) begin
                    want_st = ST_CLOSED;
                    r = REPLY_ACK;
                end else if (first_ch == CH_OPEN) begin
                    want_st = ST_OPEN;
                    r = REPLY_ACK;
                end else if (first_ch == CH_STOP) begin
                    want_st = ST_STOPPED;
                    r = REPLY_ACK;
                end
            end
            ln_len = '0;
        end else begin
            if (ln_len == 0)
                first_ch = it.rx_byte;
            if (ln_len < LINE_BUFFER_DEPTH_DEF)
                ln_len = ln_len + 5'd1;
        end
        s = {1'b0, cur_st} + ((ticks_left != 0) ? 3'd2 : 3'd0);
        return out_of(r, s, open_on, close_on);
    endfunction

    // sender: valid stays high after acceptance until the next item or an explicit release
    int calm_tx = 0;

    task automatic send_item(input t_in_item it, input bit typed = 1'b0,
                             input t_out_item want = '0);
        int gap;
        t_out_item pred;
        if (calm_tx > 0) begin
            calm_tx--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 15) == 0)
                calm_tx = 20;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = predict_relay_item(it);
        relay_results_due.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (relay_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_active_ticks(input logic [7:0] v);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(REG_ACTIVE_TICKS) << 2;
        pwdata <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_active_ticks = v;
        @(posedge i_clk);
    endtask

    task automatic send_line(input logic [7:0] first, input int len, input logic [7:0] term);
        send_item(mk_byte(first));
        for (int k = 1; k < len; k++)
            send_item(mk_byte(8'($urandom_range(0, 255))));
        send_item(mk_byte(term));
    endtask

    // receiver: per result a random stall, sometimes a calm stretch or a long hold
    initial begin : rx_side
        int stall;
        int calm_rx;
        calm_rx = 0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else if (calm_rx > 0) begin
                calm_rx--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 5);
                if ($urandom_range(0, 15) == 0)
                    calm_rx = 20;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_out_valid && i_rst_n)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : chk
        t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (relay_results_due.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out_item);
                n_err++;
            end else begin
                want = relay_results_due.pop_front();
                if (o_out_item.reply !== want.reply) begin
                    $display("%0t: reply expected %0d actual %0d",
                             $time, want.reply, o_out_item.reply);
                    n_err++;
                end
                if (o_out_item.status_code !== want.status_code) begin
                    $display("%0t: status_code expected %0d actual %0d",
                             $time, want.status_code, o_out_item.status_code);
                    n_err++;
                end
                if (o_out_item.open_relay_out !== want.open_relay_out) begin
                    $display("%0t: open_relay_out expected %0d actual %0d",
                             $time, want.open_relay_out, o_out_item.open_relay_out);
                    n_err++;
                end
                if (o_out_item.close_relay_out !== want.close_relay_out) begin
                    $display("%0t: close_relay_out expected %0d actual %0d",
                             $time, want.close_relay_out, o_out_item.close_relay_out);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    t_dir_row dir_rows[$];

    function automatic void add_row(t_in_item it, bit typed, t_out_item want);
        t_dir_row row;
        row.it = it;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endfunction

    initial begin : main
        logic [7:0] phase_cfg[6];
        logic [7:0] cmd_chars[4];
        int kind;
        int burst;
        int start_cnt;

        model_reset();
        cmd_chars = '{CH_STATUS, CH_OPEN, CH_CLOSE, CH_STOP};

        // terminators on an empty line are stored, a lone terminator line answers nak
        add_row(mk_tick(8'h00), 1, out_of(REPLY_NONE, STAT_STOPPED, 0, 0));
        add_row(mk_byte(CH_CR), 1, out_of(REPLY_NONE, STAT_STOPPED, 0, 0));
        add_row(mk_byte(CH_LF), 1, out_of(REPLY_NAK, STAT_STOPPED, 0, 0));
        add_row(mk_byte(8'h00), 0, '0);
        add_row(mk_byte(CH_LF), 1, out_of(REPLY_NAK, STAT_STOPPED, 0, 0));
        add_row(mk_byte(8'hFF), 0, '0);
        add_row(mk_byte(8'hFF), 0, '0);
        add_row(mk_byte(CH_CR), 1, out_of(REPLY_NAK, STAT_STOPPED, 0, 0));
        add_row(mk_byte(CH_STATUS), 0, '0);
        add_row(mk_byte(CH_CR), 1, out_of(REPLY_STATUS, STAT_STOPPED, 0, 0));
        add_row(mk_byte(CH_OPEN), 0, '0);
        add_row(mk_byte(CH_LF), 1, out_of(REPLY_ACK, STAT_STOPPED, 0, 0));
        // rx_byte of a tick is ignored
        add_row(mk_tick(8'hFF), 1, out_of(REPLY_NONE, STAT_OPENING, 1, 0));
        add_row(mk_byte(CH_CLOSE), 0, '0);
        add_row(mk_byte(CH_CR), 1, out_of(REPLY_ACK, STAT_OPENING, 1, 0));
        // a moving cover is stopped first, driven the other way on the next tick
        add_row(mk_tick(8'h00), 1, out_of(REPLY_NONE, STAT_STOPPED, 0, 0));
        add_row(mk_tick(8'h00), 1, out_of(REPLY_NONE, STAT_CLOSING, 0, 1));
        add_row(mk_byte(CH_STOP), 0, '0);
        add_row(mk_byte(CH_CR), 1, out_of(REPLY_ACK, STAT_CLOSING, 0, 1));
        add_row(mk_tick(8'h00), 1, out_of(REPLY_NONE, STAT_STOPPED, 0, 0));
        add_row(mk_byte(CH_OPEN), 0, '0);
        add_row(mk_byte(CH_STOP), 0, '0);
        add_row(mk_byte(CH_LF), 1, out_of(REPLY_NAK, STAT_STOPPED, 0, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

        // overlong line saturates the length and answers nak unless a random byte in it is a terminator
        send_line(CH_OPEN, 20, CH_CR);

        phase_cfg = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(1, 255)), 8'd2, ACTIVE_TICKS_RESET};
        foreach (phase_cfg[p]) begin
            write_active_ticks(phase_cfg[p]);
            if (p == 1)
                hold_request = 1'b1;
            start_cnt = items_sent;
            while (items_sent - start_cnt < PHASE_ITEMS) begin
                kind = $urandom_range(0, 9);
                if (kind <= 5)
                    send_line(cmd_chars[$urandom_range(0, 3)], 1,
                              $urandom_range(0, 1) ? CH_CR : CH_LF);
                else if (kind == 6)
                    send_line(8'($urandom_range(0, 255)), $urandom_range(2, 20),
                              $urandom_range(0, 1) ? CH_CR : CH_LF);
                else if (kind == 7)
                    send_line(8'($urandom_range(0, 255)), 1,
                              $urandom_range(0, 1) ? CH_CR : CH_LF);
                else
                    send_item(mk_byte($urandom_range(0, 1) ? CH_CR : CH_LF));
                burst = $urandom_range(0, 3);
                if ($urandom_range(0, 9) == 0)
                    burst = (phase_cfg[p] == 0) ? 5 : int'(phase_cfg[p]) + 2;
                repeat (burst) send_item(mk_tick(8'($urandom_range(0, 255))));
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (n_err == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sarc_pkg.sv
rtl/core/serial_actuator_relay_controller_top.sv
sim/testbench.sv
